>>> rtl/tsr_pkg.sv
// Shared types and constants of the telemetry slot responder.
// Used by the channel interfaces and the top level; no dependencies.
package tsr_pkg;

   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int ADDR_W  = 4;
   localparam int WORD_W  = 24;
   localparam int ENTRY_W = WORD_W + 1;
   localparam int PHASE_W = 4;

   // Event codes carried by a request beat.
   typedef enum logic [CMD_W-1:0] {
      CMD_RX    = 3'd0,
      CMD_TX    = 3'd1,
      CMD_DELAY = 3'd2,
      CMD_END   = 3'd3,
      CMD_WRITE = 3'd4
   } cmd_type;

   // Protocol phases, numbered as reported on the result channel.
   typedef enum logic [PHASE_W-1:0] {
      PH_WAIT_ADDR   = 4'd0,
      PH_WAIT_DATA1  = 4'd1,
      PH_WAIT_DATA2  = 4'd2,
      PH_WAIT_DATA3  = 4'd3,
      PH_RX_COMPLETE = 4'd4,
      PH_WAIT_DELAY  = 4'd5,
      PH_SEND_BYTE2  = 4'd6,
      PH_SEND_BYTE3  = 4'd7,
      PH_WAIT_LAST   = 4'd8,
      PH_TX_COMPLETE = 4'd9
   } phase_type;

   // One slot table entry: enable bit over three response bytes.
   typedef struct packed {
      logic              enable;
      logic [WORD_W-1:0] bytes;
   } slot_entry_type;

endpackage

>>> rtl/tsr_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on tsr_pkg for field widths.
interface tsr_req_if;
   logic                         valid;
   logic                         ready;
   logic [tsr_pkg::CMD_W-1:0]    cmd;
   logic [tsr_pkg::BYTE_W-1:0]   rx_byte;
   logic [tsr_pkg::ADDR_W-1:0]   slot_addr;
   logic                         slot_enable;
   logic [tsr_pkg::WORD_W-1:0]   slot_bytes;

   modport source (output valid, cmd, rx_byte, slot_addr, slot_enable, slot_bytes,
                   input ready);
   modport sink   (input valid, cmd, rx_byte, slot_addr, slot_enable, slot_bytes,
                   output ready);
endinterface

interface tsr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         tx_valid;
   logic [tsr_pkg::BYTE_W-1:0]   tx_byte;
   logic                         bus_drive;
   logic                         arm_slot_timer;
   logic                         arm_delay_timer;
   logic                         tx_done_wanted;
   logic [tsr_pkg::WORD_W-1:0]   rx_word;
   logic [tsr_pkg::PHASE_W-1:0]  phase;

   modport source (output valid, tx_valid, tx_byte, bus_drive, arm_slot_timer,
                   arm_delay_timer, tx_done_wanted, rx_word, phase,
                   input ready);
   modport sink   (input valid, tx_valid, tx_byte, bus_drive, arm_slot_timer,
                   arm_delay_timer, tx_done_wanted, rx_word, phase,
                   output ready);
endinterface

>>> rtl/tsr_ram.sv
// Generic RAM with one write port and two registered read ports.
// Stand-alone; read data updates only when the read enable is high.
module tsr_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

>>> rtl/telemetry_slot_responder_top.sv
// A request beat is accepted into stage two, where the slot table is read, and its result
// beat then goes through the result register. Throughput: one request beat per cycle
// unless the result side stalls; the slot table RAM read port sets the second stage.
// The result register decouples the sides: a new beat enters while a result waits.
// Reset (synchronous) clears the protocol state and the per-slot valid bits, so every
// slot reads as disabled with zero bytes until written; there is no clearing pass.
module telemetry_slot_responder_top #(
   parameter int SLOT_COUNT = 16
) (
   input  logic       clock,
   input  logic       reset,
   tsr_req_if.sink    req_ch,
   tsr_rsp_if.source  rsp_ch
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Handshake and pipeline control.
   logic req_accept;
   logic s2_move;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;

   // Stage two item.
   logic [tsr_pkg::CMD_W-1:0]  s2_cmd_ff;
   logic [tsr_pkg::BYTE_W-1:0] s2_rxb_ff;
   logic                       ok_a_ff, ok_b_ff;

   // Protocol state.
   tsr_pkg::phase_type          phase_ff, phase_in, phase_cur;
   logic [tsr_pkg::ADDR_W-1:0]  slot_ff, slot_in;
   logic [tsr_pkg::WORD_W-1:0]  word_ff, word_in;
   logic                        drive_ff, drive_in;
   logic                        txon_ff, txon_in;
   logic [SLOT_COUNT-1:0]       written_ff;

   // Step results.
   logic                       txv;
   logic [tsr_pkg::BYTE_W-1:0] txb;
   logic                       arm_slot, arm_delay;

   // Slot table access.
   logic                       wr_hit;
   logic                       rd_ok_a, rd_ok_b;
   logic [tsr_pkg::ENTRY_W-1:0] rd_data_a, rd_data_b;
   tsr_pkg::slot_entry_type    ent_a, ent_b;

   // Output register payload.
   logic                       tx_valid_ff;
   logic [tsr_pkg::BYTE_W-1:0] tx_byte_ff;
   logic                       bus_drive_ff;
   logic                       arm_slot_ff, arm_delay_ff;
   logic                       txon_out_ff;
   logic [tsr_pkg::WORD_W-1:0] rx_word_ff;
   logic [tsr_pkg::PHASE_W-1:0] phase_out_ff;

   // Stage two advances when the result register is free or being emptied.
   assign s2_move    = s2_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s2_valid_ff || s2_move;
   assign req_accept = req_ch.valid && req_ch.ready;

   assign s2_valid_in  = req_accept || (s2_valid_ff && !s2_move);
   assign out_valid_in = s2_move || (out_valid_ff && !rsp_ch.ready);

   // Table writes land at the accept edge, so later beats read the new entry.
   assign wr_hit = req_accept && (req_ch.cmd == tsr_pkg::CMD_WRITE) &&
                   ({1'b0, req_ch.slot_addr} < 5'(SLOT_COUNT));

   // Read A serves an address byte; read B serves the current slot after the
   // item now leaving stage two, which forwards any slot change it makes.
   assign rd_ok_a = ({1'b0, req_ch.rx_byte[tsr_pkg::ADDR_W-1:0]} < 5'(SLOT_COUNT)) &&
                    written_ff[req_ch.rx_byte[IDX_W-1:0]];
   assign rd_ok_b = ({1'b0, slot_in} < 5'(SLOT_COUNT)) && written_ff[slot_in[IDX_W-1:0]];

   tsr_ram #(
      .WIDTH (tsr_pkg::ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock     (clock),
      .wr_en     (wr_hit),
      .wr_addr   (req_ch.slot_addr[IDX_W-1:0]),
      .wr_data   ({req_ch.slot_enable, req_ch.slot_bytes}),
      .rd_en     (req_accept),
      .rd_addr_a (req_ch.rx_byte[IDX_W-1:0]),
      .rd_addr_b (slot_in[IDX_W-1:0]),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Entries never written read as disabled with zero bytes.
   assign ent_a = tsr_pkg::slot_entry_type'(rd_data_a & {tsr_pkg::ENTRY_W{ok_a_ff}});
   assign ent_b = tsr_pkg::slot_entry_type'(rd_data_b & {tsr_pkg::ENTRY_W{ok_b_ff}});

   // Written flags for the slot table entries.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_hit) begin
         written_ff[req_ch.slot_addr[IDX_W-1:0]] <= 1'b1;
      end
   end

   // Stage two capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s2_cmd_ff <= req_ch.cmd;
         s2_rxb_ff <= req_ch.rx_byte;
         ok_a_ff   <= rd_ok_a;
         ok_b_ff   <= rd_ok_b;
      end
   end

   // Protocol state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tsr_pkg::PH_WAIT_ADDR;
         slot_ff  <= '0;
         word_ff  <= '0;
         drive_ff <= 1'b0;
         txon_ff  <= 1'b0;
      end else if (s2_move) begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         word_ff  <= word_in;
         drive_ff <= drive_in;
         txon_ff  <= txon_in;
      end
   end

   // Next protocol state and step outputs for the item in stage two.
   always_comb begin
      phase_cur = phase_ff;
      phase_in  = phase_ff;
      slot_in   = slot_ff;
      word_in   = word_ff;
      drive_in  = drive_ff;
      txon_in   = txon_ff;
      txv       = 1'b0;
      txb       = '0;
      arm_slot  = 1'b0;
      arm_delay = 1'b0;
      if (s2_move && (s2_cmd_ff <= tsr_pkg::CMD_END)) begin
         // Slot end releases the bus and resyncs before the phase dispatch.
         if (s2_cmd_ff == tsr_pkg::CMD_END) begin
            drive_in  = 1'b0;
            phase_cur = tsr_pkg::PH_WAIT_ADDR;
         end
         phase_in = phase_cur;
         unique case (phase_cur)
            tsr_pkg::PH_WAIT_ADDR: begin
               if (s2_cmd_ff == tsr_pkg::CMD_RX) begin
                  arm_slot = 1'b1;
                  slot_in  = s2_rxb_ff[tsr_pkg::ADDR_W-1:0];
                  if (ent_a.enable) begin
                     drive_in  = 1'b1;
                     arm_delay = 1'b1;
                     phase_in  = tsr_pkg::PH_WAIT_DELAY;
                  end else begin
                     phase_in = tsr_pkg::PH_WAIT_DATA1;
                  end
               end
            end
            tsr_pkg::PH_WAIT_DATA1: begin
               if (s2_cmd_ff == tsr_pkg::CMD_RX) begin
                  word_in  = {16'h0000, s2_rxb_ff};
                  phase_in = tsr_pkg::PH_WAIT_DATA2;
               end
            end
            tsr_pkg::PH_WAIT_DATA2: begin
               if (s2_cmd_ff == tsr_pkg::CMD_RX) begin
                  word_in  = word_ff | {8'h00, s2_rxb_ff, 8'h00};
                  phase_in = tsr_pkg::PH_WAIT_DATA3;
               end
            end
            tsr_pkg::PH_WAIT_DATA3: begin
               if (s2_cmd_ff == tsr_pkg::CMD_RX) begin
                  word_in  = word_ff | {s2_rxb_ff, 16'h0000};
                  phase_in = tsr_pkg::PH_RX_COMPLETE;
               end
            end
            tsr_pkg::PH_RX_COMPLETE: begin
               phase_in = phase_cur;
            end
            tsr_pkg::PH_WAIT_DELAY: begin
               if (s2_cmd_ff == tsr_pkg::CMD_DELAY) begin
                  txv      = 1'b1;
                  txb      = ent_b.bytes[7:0];
                  txon_in  = 1'b1;
                  phase_in = tsr_pkg::PH_SEND_BYTE2;
               end
            end
            tsr_pkg::PH_SEND_BYTE2: begin
               if (s2_cmd_ff == tsr_pkg::CMD_TX) begin
                  txv      = 1'b1;
                  txb      = ent_b.bytes[15:8];
                  phase_in = tsr_pkg::PH_SEND_BYTE3;
               end
            end
            tsr_pkg::PH_SEND_BYTE3: begin
               if (s2_cmd_ff == tsr_pkg::CMD_TX) begin
                  txv      = 1'b1;
                  txb      = ent_b.bytes[23:16];
                  phase_in = tsr_pkg::PH_WAIT_LAST;
               end
            end
            tsr_pkg::PH_WAIT_LAST: begin
               if (s2_cmd_ff == tsr_pkg::CMD_TX) begin
                  txon_in  = 1'b0;
                  phase_in = tsr_pkg::PH_TX_COMPLETE;
               end
            end
            tsr_pkg::PH_TX_COMPLETE: begin
               phase_in = phase_cur;
            end
            default: begin
               // Unused phase codes recover to waiting for an address.
               phase_in = tsr_pkg::PH_WAIT_ADDR;
            end
         endcase
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         tx_valid_ff  <= txv;
         tx_byte_ff   <= txb;
         bus_drive_ff <= drive_in;
         arm_slot_ff  <= arm_slot;
         arm_delay_ff <= arm_delay;
         txon_out_ff  <= txon_in;
         rx_word_ff   <= word_in;
         phase_out_ff <= phase_in;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.tx_valid        = tx_valid_ff;
   assign rsp_ch.tx_byte         = tx_byte_ff;
   assign rsp_ch.bus_drive       = bus_drive_ff;
   assign rsp_ch.arm_slot_timer  = arm_slot_ff;
   assign rsp_ch.arm_delay_timer = arm_delay_ff;
   assign rsp_ch.tx_done_wanted  = txon_out_ff;
   assign rsp_ch.rx_word         = rx_word_ff;
   assign rsp_ch.phase           = phase_out_ff;

`ifndef SYNTHESIS
   // The bus is driven exactly in the transmit phases.
   a_drive_phase: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (bus_drive_ff == ((phase_out_ff >= tsr_pkg::PH_WAIT_DELAY) &&
                                         (phase_out_ff <= tsr_pkg::PH_TX_COMPLETE))))
      else $error("bus drive does not match the reported phase");

   // A byte goes out only when entering a send or wait-last phase.
   a_tx_phase: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && tx_valid_ff) |->
         ((phase_out_ff == tsr_pkg::PH_SEND_BYTE2) ||
          (phase_out_ff == tsr_pkg::PH_SEND_BYTE3) ||
          (phase_out_ff == tsr_pkg::PH_WAIT_LAST)))
      else $error("byte sent outside a send phase");

   // Arming the delay timer always comes with an address byte that takes the bus.
   a_arm_pair: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && arm_delay_ff) |-> (arm_slot_ff && bus_drive_ff))
      else $error("delay timer armed without slot timer or bus drive");

   // A held stage two item blocks new beats and keeps its state untouched.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_move) |=> (s2_valid_ff && $stable(phase_ff) && $stable(slot_ff)))
      else $error("stalled stage two lost its item or changed state");

   // A result waiting on the output is never overwritten.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |-> !s2_move)
      else $error("result register overwritten while full");
`endif

endmodule
